// ===== design/video_row_packet_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the video row packet deframer
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef VIDEO_ROW_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define VIDEO_ROW_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define VRPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VRPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vrpd_pkg
// Types, codes and constants of the video row packet deframer.
// ----------------------------------------------------------------------------
package vrpd_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 4096;
    localparam int unsigned FRAME_WORDS      = 8388608;
    localparam int unsigned HEADER_BYTES     = 16;
    localparam int unsigned MIN_PACKET       = 12;
    localparam int unsigned BUFFER_COUNT     = 2;

    localparam int unsigned POS_W      = 16;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned ADDR_W     = 23;
    localparam int unsigned BASE_W     = 2 * FIELD_W;
    localparam int unsigned DIVIDEND_W = FIELD_W + 1;
    localparam int unsigned CNT_W      = $clog2(DIVIDEND_W);
    localparam int unsigned BUF_W      = $clog2(BUFFER_COUNT);

    // header byte positions
    localparam logic [POS_W-1:0] HP_SYNC0   = 16'd0;
    localparam logic [POS_W-1:0] HP_SYNC1   = 16'd1;
    localparam logic [POS_W-1:0] HP_SYNC2   = 16'd2;
    localparam logic [POS_W-1:0] HP_SYNC3   = 16'd3;
    localparam logic [POS_W-1:0] HP_COLS_LO = 16'd4;
    localparam logic [POS_W-1:0] HP_COLS_HI = 16'd5;
    localparam logic [POS_W-1:0] HP_ROWS_LO = 16'd6;
    localparam logic [POS_W-1:0] HP_ROWS_HI = 16'd7;
    localparam logic [POS_W-1:0] HP_IDX_LO  = 16'd10;
    localparam logic [POS_W-1:0] HP_IDX_HI  = 16'd11;

    localparam logic [7:0] SYNC_0 = 8'h00;
    localparam logic [7:0] SYNC_1 = 8'h00;
    localparam logic [7:0] SYNC_2 = 8'h90;
    localparam logic [7:0] SYNC_3 = 8'hEB;

    // result kinds; packet status shares the codes
    localparam logic [2:0] STATUS_FINE   = 3'd0;
    localparam logic [2:0] KIND_PIXEL    = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED = 3'd1;
    localparam logic [2:0] KIND_SIZE     = 3'd2;
    localparam logic [2:0] KIND_HEADER   = 3'd3;
    localparam logic [2:0] KIND_FIELDS   = 3'd4;
    localparam logic [2:0] KIND_SHORT    = 3'd5;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic [POS_W-1:0]   packet_length;
        logic               end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [BUF_W-1:0]   buffer_select;
        logic [ADDR_W-1:0]  pixel_address;
        logic [FIELD_W-1:0] pixel_value;
        logic               row_gap;
        logic               frame_done;
        logic [BUF_W-1:0]   ready_buffer;
        logic [FIELD_W-1:0] frame_rows;
        logic [FIELD_W-1:0] frame_cols;
        logic               write_overflow;
        logic               last_result;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic start_calc;
        logic out_load_new;
        logic out_load_pend;
        logic pend_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       need_calc;
        logic       calc_busy;
        logic [1:0] res_count;
    } t_dp_stat;

endpackage

// ===== design/vrpd_rem.sv =====
// ----------------------------------------------------------------------------
// vrpd_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module vrpd_rem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [vrpd_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [vrpd_pkg::FIELD_W-1:0]       i_divisor,
    output logic                               o_busy,
    output logic [vrpd_pkg::FIELD_W-1:0]       o_remainder
);

    logic                              r_busy;
    logic [vrpd_pkg::CNT_W-1:0]        r_cnt;
    logic [vrpd_pkg::FIELD_W-1:0]      r_rem;
    logic [vrpd_pkg::DIVIDEND_W-1:0]   r_dvd;
    logic [vrpd_pkg::FIELD_W-1:0]      r_div;

    logic [vrpd_pkg::FIELD_W:0]        trial;
    logic [vrpd_pkg::FIELD_W:0]        diff;
    logic [vrpd_pkg::FIELD_W-1:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[vrpd_pkg::DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[vrpd_pkg::FIELD_W-1:0];
        end else begin
            n_rem = trial[vrpd_pkg::FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= vrpd_pkg::CNT_W'(vrpd_pkg::DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[vrpd_pkg::DIVIDEND_W-2:0], 1'b0};
        end
    end

    assign o_busy      = r_busy;
    assign o_remainder = r_rem;

endmodule

// ===== design/vrpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrpd_ctrl
// Handshake and sequencing controller: byte acceptance, row check wait,
// output register and pending slot.
// ----------------------------------------------------------------------------
module vrpd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  vrpd_pkg::t_dp_stat  i_stat,
    output vrpd_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_calc_done, n_calc_done;
    logic   r_out_vld, n_out_vld;
    logic   r_pend_vld, n_pend_vld;

    logic   out_free;
    logic   calc_wait;
    logic   in_ready;

    always_comb begin
        n_state     = r_state;
        n_calc_done = r_calc_done;
        n_out_vld   = r_out_vld;
        n_pend_vld  = r_pend_vld;
        o_cmd       = '0;
        in_ready    = 1'b0;
        out_free    = !r_out_vld || i_out_ready;
        calc_wait   = i_stat.need_calc && !r_calc_done;

        case (r_state)
            ST_RUN: begin
                in_ready = !calc_wait && !r_pend_vld && out_free;
                if (i_in_valid && calc_wait) begin
                    o_cmd.start_calc = 1'b1;
                    n_state          = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!i_stat.calc_busy) begin
                    n_calc_done = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        o_cmd.accept = i_in_valid && in_ready;

        if (o_cmd.accept) begin
            n_calc_done        = 1'b0;
            o_cmd.out_load_new = (i_stat.res_count != 2'd0);
            o_cmd.pend_load    = (i_stat.res_count == 2'd2);
            n_out_vld          = (i_stat.res_count != 2'd0);
            n_pend_vld         = (i_stat.res_count == 2'd2);
        end else if (r_out_vld && i_out_ready) begin
            if (r_pend_vld) begin
                o_cmd.out_load_pend = 1'b1;
                n_pend_vld          = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_calc_done <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_calc_done <= n_calc_done;
            r_out_vld   <= n_out_vld;
            r_pend_vld  <= n_pend_vld;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_vld;

endmodule

// ===== design/vrpd_dpath.sv =====
// ----------------------------------------------------------------------------
// vrpd_dpath
// Deframer datapath: packet state, header fields, row bookkeeping, pixel
// address generation, result build and output staging.
// ----------------------------------------------------------------------------
module vrpd_dpath #(
    parameter int unsigned MAX_PACKET_BYTES = vrpd_pkg::MAX_PACKET_BYTES,
    parameter int unsigned FRAME_WORDS      = vrpd_pkg::FRAME_WORDS,
    parameter int unsigned HEADER_BYTES     = vrpd_pkg::HEADER_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrpd_pkg::t_in_item  i_in_data,
    input  vrpd_pkg::t_dp_cmd   i_cmd,
    output vrpd_pkg::t_dp_stat  o_stat,
    output vrpd_pkg::t_out_item o_out_data
);

    localparam int unsigned PW = vrpd_pkg::POS_W;
    localparam int unsigned FW = vrpd_pkg::FIELD_W;
    localparam int unsigned BW = vrpd_pkg::BASE_W;

    // control state
    logic [PW-1:0]  r_pos;
    logic [2:0]     r_status;
    logic           r_gap, r_done, r_ovf;
    logic           r_wbuf, r_cbuf;
    logic [FW-1:0]  r_prev;

    // payload state
    logic [7:0]     r_sync [0:2];
    logic [FW-1:0]  r_cols, r_rows;
    logic [7:0]     r_idx_lo;
    logic [BW-1:0]  r_base;
    logic [7:0]     r_low;
    vrpd_pkg::t_out_item r_out, r_pend;

    logic [7:0]     b;
    logic [PW-1:0]  len;
    logic           eop;
    logic [2:0]     status0, status1, status2;
    logic           fine0, hdr_ok, fields_ok, at_last_hdr, need_calc;
    logic [FW-1:0]  idx, idx_m1, idx_mod;
    logic [BW-1:0]  base_next;
    logic           gap1, done1, ovf1;
    logic           pix_pos, pix_odd, in_cols, in_store, pix_emit, pix_ovf;
    logic [PW-1:0]  off;
    logic [PW-2:0]  col_i;
    logic [BW:0]    addr;
    logic           stat_ok;
    vrpd_pkg::t_out_item pix_res, stat_res, res0;

    logic [vrpd_pkg::DIVIDEND_W-1:0] dividend;
    logic [FW-1:0]  rem;
    logic           rem_busy;

    assign dividend = {1'b0, r_prev} + vrpd_pkg::DIVIDEND_W'(1);

    vrpd_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start_calc),
        .i_dividend  (dividend),
        .i_divisor   (r_rows),
        .o_busy      (rem_busy),
        .o_remainder (rem)
    );

    always_comb begin
        b   = i_in_data.data_byte;
        len = i_in_data.packet_length;
        eop = i_in_data.end_of_packet;

        status0 = r_status;
        if (r_pos == '0) begin
            if (len == '0 || len > PW'(MAX_PACKET_BYTES)) begin
                status0 = vrpd_pkg::KIND_SIZE;
            end else if (len < PW'(vrpd_pkg::MIN_PACKET)) begin
                status0 = vrpd_pkg::KIND_SHORT;
            end
        end
        fine0 = (status0 == vrpd_pkg::STATUS_FINE);

        hdr_ok = (r_sync[0] == vrpd_pkg::SYNC_0) && (r_sync[1] == vrpd_pkg::SYNC_1) &&
                 (r_sync[2] == vrpd_pkg::SYNC_2) && (b == vrpd_pkg::SYNC_3);

        idx         = {b, r_idx_lo};
        idx_m1      = idx - FW'(1);
        fields_ok   = (idx != '0) && (idx <= r_rows) && (r_cols != '0);
        at_last_hdr = (r_pos == vrpd_pkg::HP_IDX_HI);
        need_calc   = fine0 && at_last_hdr && fields_ok;

        status1 = status0;
        if (fine0 && r_pos == vrpd_pkg::HP_SYNC3 && !hdr_ok) begin
            status1 = vrpd_pkg::KIND_HEADER;
        end else if (fine0 && at_last_hdr && !fields_ok) begin
            status1 = vrpd_pkg::KIND_FIELDS;
        end

        idx_mod   = (idx == r_rows) ? '0 : idx;
        base_next = {{(BW-FW){1'b0}}, idx_m1} * {{(BW-FW){1'b0}}, r_cols};

        pix_pos  = fine0 && (r_pos >= PW'(HEADER_BYTES)) && (r_pos < len);
        off      = r_pos - PW'(HEADER_BYTES);
        pix_odd  = off[0];
        col_i    = off[PW-1:1];
        in_cols  = ({1'b0, col_i} < r_cols);
        addr     = {1'b0, r_base} + (BW+1)'(col_i);
        in_store = (addr < (BW+1)'(FRAME_WORDS));
        pix_emit = pix_pos && pix_odd && in_cols && in_store;
        pix_ovf  = pix_pos && pix_odd && in_cols && !in_store;

        gap1  = r_gap  || (need_calc && (rem != idx_mod));
        done1 = r_done || (need_calc && (idx == r_rows));
        ovf1  = r_ovf  || pix_ovf;

        status2 = status1;
        if (status1 == vrpd_pkg::STATUS_FINE && r_pos < vrpd_pkg::HP_IDX_HI) begin
            status2 = vrpd_pkg::KIND_SHORT;
        end
        stat_ok = (status2 == vrpd_pkg::STATUS_FINE);

        pix_res               = '0;
        pix_res.kind          = vrpd_pkg::KIND_PIXEL;
        pix_res.buffer_select = r_wbuf;
        pix_res.pixel_address = addr[vrpd_pkg::ADDR_W-1:0];
        pix_res.pixel_value   = {b, r_low};
        pix_res.ready_buffer  = r_cbuf;
        pix_res.last_result   = !eop;

        stat_res              = '0;
        stat_res.last_result  = 1'b1;
        stat_res.ready_buffer = r_cbuf;
        if (stat_ok) begin
            stat_res.kind           = vrpd_pkg::KIND_ACCEPTED;
            stat_res.row_gap        = gap1;
            stat_res.frame_done     = done1;
            stat_res.frame_rows     = r_rows;
            stat_res.frame_cols     = r_cols;
            stat_res.write_overflow = ovf1;
            if (done1) begin
                stat_res.ready_buffer = r_wbuf;
            end
        end else begin
            stat_res.kind = status2;
        end

        res0 = pix_emit ? pix_res : stat_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_status <= vrpd_pkg::STATUS_FINE;
            r_gap    <= 1'b0;
            r_done   <= 1'b0;
            r_ovf    <= 1'b0;
            r_wbuf   <= 1'b0;
            r_cbuf   <= 1'b0;
            r_prev   <= '0;
        end else if (i_cmd.accept) begin
            if (need_calc) begin
                r_prev <= idx;
            end
            if (eop) begin
                r_pos    <= '0;
                r_status <= vrpd_pkg::STATUS_FINE;
                r_gap    <= 1'b0;
                r_done   <= 1'b0;
                r_ovf    <= 1'b0;
                if (stat_ok && done1) begin
                    r_cbuf <= r_wbuf;
                    r_wbuf <= !r_wbuf;
                end
            end else begin
                if (r_pos != '1) begin
                    r_pos <= r_pos + PW'(1);
                end
                r_status <= status1;
                r_gap    <= gap1;
                r_done   <= done1;
                r_ovf    <= ovf1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && fine0) begin
            case (r_pos)
                vrpd_pkg::HP_SYNC0:   r_sync[0]              <= b;
                vrpd_pkg::HP_SYNC1:   r_sync[1]              <= b;
                vrpd_pkg::HP_SYNC2:   r_sync[2]              <= b;
                vrpd_pkg::HP_COLS_LO: r_cols[7:0]            <= b;
                vrpd_pkg::HP_COLS_HI: r_cols[FW-1:8]         <= b;
                vrpd_pkg::HP_ROWS_LO: r_rows[7:0]            <= b;
                vrpd_pkg::HP_ROWS_HI: r_rows[FW-1:8]         <= b;
                vrpd_pkg::HP_IDX_LO:  r_idx_lo               <= b;
                default: begin
                end
            endcase
        end
        if (i_cmd.accept && need_calc) begin
            r_base <= base_next;
        end
        if (i_cmd.accept && pix_pos && !pix_odd) begin
            r_low <= b;
        end
        if (i_cmd.out_load_new) begin
            r_out <= res0;
        end else if (i_cmd.out_load_pend) begin
            r_out <= r_pend;
        end
        if (i_cmd.pend_load) begin
            r_pend <= stat_res;
        end
    end

    assign o_stat.need_calc = need_calc;
    assign o_stat.calc_busy = rem_busy;
    assign o_stat.res_count = 2'(pix_emit) + 2'(eop);
    assign o_out_data       = r_out;

endmodule

// ===== design/video_row_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// video_row_packet_deframer_unit
// Row datagram deframer: header check, row bookkeeping and pixel writes
// into a double-buffered frame store.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle while results drain, and emits pixel
// writes plus one status item per datagram. A byte that yields both a pixel
// write and the status item parks the status item in the pending slot and
// holds the input until that slot drains. The last index byte of a
// well-formed header is held while the row-gap test works out
// (previous row + 1) mod rows in a restoring remainder unit, one dividend
// bit per cycle. Results pass through an output register with one pending slot.
// ----------------------------------------------------------------------------
module video_row_packet_deframer_unit #(
    parameter int unsigned MAX_PACKET_BYTES = vrpd_pkg::MAX_PACKET_BYTES,
    parameter int unsigned FRAME_WORDS      = vrpd_pkg::FRAME_WORDS,
    parameter int unsigned HEADER_BYTES     = vrpd_pkg::HEADER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vrpd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vrpd_pkg::t_out_item  o_out_data
);

    vrpd_pkg::t_dp_cmd  dp_cmd;
    vrpd_pkg::t_dp_stat dp_stat;

    vrpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    vrpd_dpath #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .FRAME_WORDS      (FRAME_WORDS),
        .HEADER_BYTES     (HEADER_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

`include "video_row_packet_deframer_unit_assert.svh"

    `VRPD_ASSERT_IMPLY(a_ready_needs_room, i_clk, i_rst_n, o_in_ready, !o_out_valid || i_out_ready, "input ready while output slot is held")
    `VRPD_ASSERT_NEXT(a_calc_starts, i_clk, i_rst_n, dp_cmd.start_calc, dp_stat.calc_busy, "remainder unit did not start")
    `VRPD_ASSERT_IMPLY(a_hold_during_calc, i_clk, i_rst_n, dp_stat.calc_busy, !o_in_ready, "input ready while remainder unit runs")
    `VRPD_ASSERT_IMPLY(a_pend_with_out, i_clk, i_rst_n, dp_cmd.pend_load, dp_cmd.out_load_new, "pending slot loaded without output load")

endmodule
